### hdl/urrb_pkg.sv
// ----------------------------------------------------------------------------
// urrb_pkg
// Shared types and constants for the UART receive ring buffer.
// ----------------------------------------------------------------------------
package urrb_pkg;

   localparam int DEPTH   = 256;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int LEVEL_W = (PTR_W + 1 > 8) ? PTR_W + 1 : 8;
   localparam int CNT_W   = 32;
   localparam int FILL_W  = 8;

   typedef enum logic [1:0] {
      ACT_RECEIVE = 2'd0,
      ACT_READ    = 2'd1,
      ACT_FLUSH   = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   // Buffer operations, already qualified by the transaction handshake.
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } urrb_ops_type;

   // Buffer status seen before the current operation.
   typedef struct packed {
      logic              full;
      logic              empty;
      logic [FILL_W-1:0] level;
   } urrb_stat_type;

endpackage

### hdl/urrb_ring.sv
// ----------------------------------------------------------------------------
// urrb_ring
// Byte store with write and read pointers; keeps one slot free.
// ----------------------------------------------------------------------------
module urrb_ring
   import urrb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  urrb_ops_type  ops,
   input  logic [7:0]    wr_data,
   output urrb_stat_type stat,
   output logic [7:0]    rd_data
);

   logic [7:0]       byte_store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;
   logic [LEVEL_W-1:0] level;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_next = ptr_next(wr_ptr_ff);
      rd_next = ptr_next(rd_ptr_ff);
      // Pointers need not wrap at a power of two, so the level is formed explicitly.
      if (wr_ptr_ff >= rd_ptr_ff) begin
         level = LEVEL_W'(wr_ptr_ff) - LEVEL_W'(rd_ptr_ff);
      end else begin
         level = LEVEL_W'(DEPTH) - LEVEL_W'(rd_ptr_ff) + LEVEL_W'(wr_ptr_ff);
      end
      stat.full  = (wr_next == rd_ptr_ff);
      stat.empty = (wr_ptr_ff == rd_ptr_ff);
      stat.level = level[FILL_W-1:0];

      wr_ptr_in = ops.push ? wr_next : wr_ptr_ff;
      if (ops.pop) begin
         rd_ptr_in = rd_next;
      end else if (ops.flush) begin
         rd_ptr_in = wr_ptr_ff;
      end else begin
         rd_ptr_in = rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ops.push) begin
         byte_store[wr_ptr_ff] <= wr_data;
      end
   end

   // Read data holds until the next pop, so a stalled result keeps its byte.
   always_ff @(posedge clock) begin
      if (ops.pop) begin
         rd_data_ff <= byte_store[rd_ptr_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/uart_receive_ring_buffer.sv
// ----------------------------------------------------------------------------
// uart_receive_ring_buffer
// Receive side of a serial port: byte ring buffer and error counters.
// ----------------------------------------------------------------------------
// Timing: an accepted transaction is held in a pending stage, then moves to
// the output register that drives rsp_tvalid once the result side is free.
// Throughput: one transaction per cycle while the result side keeps up; the
// registered read of the byte store is covered by a pending stage.
// Reset: synchronous; pointers and counters clear, receive is enabled, and
// the byte store itself is not cleared.
module uart_receive_ring_buffer
   import urrb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,   // rx_enable
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,     // rx_byte, has_byte, overrun_flag,
                                       // framing_flag, noise_flag, zero pad
   input  logic [1:0]   req_tuser,     // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,     // read_byte, fill_count, dropped_count,
                                       // hw_overrun_count, framing_count,
                                       // noise_count
   output logic         rsp_tuser      // byte_valid
);

   logic rx_enable_ff;

   logic [CNT_W-1:0] drop_ff, drop_in;
   logic [CNT_W-1:0] ovr_ff, ovr_in;
   logic [CNT_W-1:0] frm_ff, frm_in;
   logic [CNT_W-1:0] noi_ff, noi_in;

   logic pend_ff, pend_in;
   logic pend_byte_ff, pend_byte_in;
   logic out_valid_ff, out_valid_in;
   logic out_byte_valid_ff;
   logic [7:0]        out_byte_ff;
   logic [FILL_W-1:0] out_fill_ff;
   logic [CNT_W-1:0]  out_drop_ff, out_ovr_ff, out_frm_ff, out_noi_ff;

   logic          accept;
   logic          out_free;
   logic          pend_move;
   action_type    action;
   logic [7:0]    rx_byte;
   logic          has_byte;
   urrb_ops_type  ops;
   urrb_stat_type stat;
   logic [7:0]    rd_data;
   logic          is_recv;

   assign action   = action_type'(req_tuser);
   assign rx_byte  = req_tdata[7:0];
   assign has_byte = req_tdata[8];

   assign out_free   = !out_valid_ff || rsp_tready;
   assign pend_move  = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_recv    = accept && (action == ACT_RECEIVE);

   always_comb begin
      ops.push  = is_recv && has_byte && rx_enable_ff && !stat.full;
      ops.pop   = accept && (action == ACT_READ) && rx_enable_ff && !stat.empty;
      ops.flush = accept && (action == ACT_FLUSH) && rx_enable_ff;

      drop_in = drop_ff;
      ovr_in  = ovr_ff;
      frm_in  = frm_ff;
      noi_in  = noi_ff;
      if (accept && (action == ACT_CLEAR)) begin
         drop_in = '0;
         ovr_in  = '0;
         frm_in  = '0;
         noi_in  = '0;
      end else if (is_recv) begin
         // A byte received while disabled is discarded, not counted as dropped.
         if (has_byte && rx_enable_ff && stat.full) begin
            drop_in = drop_ff + 1'b1;
         end
         if (req_tdata[9]) begin
            ovr_in = ovr_ff + 1'b1;
         end
         if (req_tdata[10]) begin
            frm_in = frm_ff + 1'b1;
         end
         if (req_tdata[11]) begin
            noi_in = noi_ff + 1'b1;
         end
      end

      if (accept) begin
         pend_in = 1'b1;
      end else if (pend_move) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
      pend_byte_in = accept ? ops.pop : pend_byte_ff;

      if (pend_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   urrb_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .ops     (ops),
      .wr_data (rx_byte),
      .stat    (stat),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff <= 1'b1;
         drop_ff      <= '0;
         ovr_ff       <= '0;
         frm_ff       <= '0;
         noi_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rx_enable_ff <= csr_wr_data;
         end
         drop_ff      <= drop_in;
         ovr_ff       <= ovr_in;
         frm_ff       <= frm_in;
         noi_ff       <= noi_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The pending transaction already updated pointers and counters, so the
   // live values are exactly its result when it moves to the output.
   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      if (pend_move) begin
         out_byte_valid_ff <= pend_byte_ff;
         out_byte_ff       <= pend_byte_ff ? rd_data : 8'd0;
         out_fill_ff       <= rx_enable_ff ? stat.level : '0;
         out_drop_ff       <= drop_ff;
         out_ovr_ff        <= ovr_ff;
         out_frm_ff        <= frm_ff;
         out_noi_ff        <= noi_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_byte_valid_ff;
   assign rsp_tdata  = {out_noi_ff, out_frm_ff, out_ovr_ff, out_drop_ff,
                        out_fill_ff, out_byte_ff};

endmodule
